// ----- design/jac_pkg.sv -----
package jac_pkg;

  localparam int AXES        = 4;
  localparam int SAMPLE_BITS = 12;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX   = {SAMPLE_BITS{1'b1}};
  localparam logic [SAMPLE_BITS-1:0] CENTER_RESET = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Configuration register widths and reset values.
  localparam int DZ_W    = 12;
  localparam int SENS_W  = 10;
  localparam int ALPHA_W = 9;

  localparam logic [DZ_W-1:0]    DZ_RESET    = DZ_W'(102);
  localparam logic [SENS_W-1:0]  SENS_RESET  = SENS_W'(256);
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(51);
  localparam logic [ALPHA_W-1:0] ALPHA_MAX   = ALPHA_W'(256);

  localparam int POS_W = 16;
  localparam logic signed [POS_W-1:0] POS_SAT = POS_W'(32767);

  // Width that holds both the deadzone and the sample magnitude with room for 3x.
  localparam int CMP_W = ((SAMPLE_BITS > DZ_W) ? SAMPLE_BITS : DZ_W) + 2;

  // magnitude * sensitivity, then the dividend is that product times 128.
  localparam int PROD_W    = SAMPLE_BITS + SENS_W;
  localparam int DIV_STEPS = 15;
  localparam int CNT_W     = 4;
  localparam int ACC_W     = POS_W + ALPHA_W + 2;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_DEADZONE = 2'd0,
    REG_SENS     = 2'd1,
    REG_FILT_EN  = 2'd2,
    REG_ALPHA    = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_CENTER,
    S_DSTART,
    S_DIV,
    S_VAL,
    S_MUL,
    S_ROUND,
    S_EMIT
  } state_e;

endpackage

// ----- design/joystick_axis_conditioner_core.sv -----
// A sample passes prepare, center, divider start, divide, value, multiply, round
// and emit; one inside the deadzone goes from center to emit. A recalibrate item
// only latches the center. One item at a time: a new one waits until the last leaves
// emit. A 15-step bit-serial restoring divider scales the offset by the span.
// Reset (rst_ni low, asynchronous): registers to their defaults, every center to
// mid-scale and not yet latched, every filter state to zero, output empty.
module joystick_axis_conditioner_core
  import jac_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,

  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready,

  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     kind_i,
  input  logic [1:0]               axis_i,
  input  logic [SAMPLE_BITS-1:0]   sample_i,

  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               axis_out_o,
  output logic signed [POS_W-1:0]  position_o,
  output logic                     in_deadzone_o
);

  // Configuration registers
  logic [DZ_W-1:0]    dz_q;
  logic [SENS_W-1:0]  sens_q;
  logic               fen_q;
  logic [ALPHA_W-1:0] alpha_q;

  // Per-axis state
  logic [SAMPLE_BITS-1:0]  center_q [AXES];
  logic [AXES-1:0]         cvalid_q;
  logic signed [POS_W-1:0] smooth_q [AXES];

  // Work registers
  state_e                  state_q, state_d;
  logic [1:0]              axis_q;
  logic [SAMPLE_BITS-1:0]  sample_q;
  logic [SAMPLE_BITS-1:0]  cur_c_q;
  logic                    first_q;
  logic [SAMPLE_BITS-1:0]  mag_q;
  logic                    neg_q;
  logic [SAMPLE_BITS-1:0]  span_q;
  logic [PROD_W-1:0]       prod_q;
  logic                    sat_q;
  logic [SAMPLE_BITS-1:0]  rem_q;
  logic [DIV_STEPS-1:0]    num_sr_q;
  logic [DIV_STEPS-1:0]    quot_q;
  logic [CNT_W-1:0]        cnt_q;
  logic signed [POS_W-1:0] val_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [POS_W-1:0] res_pos_q;
  logic                    res_dz_q;

  logic                    out_valid_q;
  logic [1:0]              out_axis_q;
  logic signed [POS_W-1:0] out_pos_q;
  logic                    out_dz_q;

  logic in_xfer, cfg_wr, out_load, out_free, div_last;

  // ---------------------------------------------------------------------------
  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    prdata = '0;
    unique case (reg_idx_e'(paddr[3:2]))
      REG_DEADZONE: prdata = PDATA_W'(dz_q);
      REG_SENS:     prdata = PDATA_W'(sens_q);
      REG_FILT_EN:  prdata = PDATA_W'(fen_q);
      REG_ALPHA:    prdata = PDATA_W'(alpha_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q    <= DZ_RESET;
      sens_q  <= SENS_RESET;
      fen_q   <= 1'b1;
      alpha_q <= ALPHA_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[3:2]))
        REG_DEADZONE: dz_q    <= pwdata[DZ_W-1:0];
        REG_SENS:     sens_q  <= pwdata[SENS_W-1:0];
        REG_FILT_EN:  fen_q   <= pwdata[0];
        REG_ALPHA:    alpha_q <= pwdata[ALPHA_W-1:0];
        default:      ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath arithmetic
  logic [SAMPLE_BITS-1:0] c_eff;
  logic [SAMPLE_BITS:0]   delta;
  logic [SAMPLE_BITS:0]   delta_abs;

  assign c_eff     = cvalid_q[axis_q] ? center_q[axis_q] : sample_q;
  assign delta     = {1'b0, sample_q} - {1'b0, c_eff};
  assign delta_abs = delta[SAMPLE_BITS] ? (~delta + 1'b1) : delta;

  logic [CMP_W-1:0]       dz_ext, dz3, mag_ext;
  logic                   in_dz, near_dz;
  logic [SAMPLE_BITS+4:0] c15_sum;
  logic [SAMPLE_BITS+5:0] c31_sum;
  logic [SAMPLE_BITS-1:0] c_new, span_raw, span_new;
  logic [PROD_W-1:0]      prod;

  assign dz_ext  = CMP_W'(dz_q);
  assign dz3     = (dz_ext << 1) + dz_ext;
  assign mag_ext = CMP_W'(mag_q);
  assign in_dz   = mag_ext <= dz_ext;
  assign near_dz = mag_ext < dz3;

  // Center drift: c*15+s over 16 and c*31+s over 32, both truncating.
  assign c15_sum = ({5'b0, cur_c_q} << 4) - {5'b0, cur_c_q} + {5'b0, sample_q};
  assign c31_sum = ({6'b0, cur_c_q} << 5) - {6'b0, cur_c_q} + {6'b0, sample_q};

  always_comb begin
    if (in_dz)        c_new = c15_sum[SAMPLE_BITS+3:4];
    else if (near_dz) c_new = c31_sum[SAMPLE_BITS+4:5];
    else              c_new = cur_c_q;
  end

  assign span_raw = neg_q ? c_new : (SAMPLE_MAX - c_new);
  assign span_new = (span_raw == '0) ? SAMPLE_BITS'(1) : span_raw;
  assign prod     = PROD_W'(mag_q) * PROD_W'(sens_q);

  // The dividend is prod*128; the quotient saturates once prod/256 reaches the span.
  logic [SAMPLE_BITS+1:0] prod_hi;
  logic                   sat_new;
  assign prod_hi = prod_q[PROD_W-1:8];
  assign sat_new = prod_hi >= {2'b0, span_q};

  logic [SAMPLE_BITS:0] trial;
  logic [SAMPLE_BITS:0] trial_sub;
  logic                 trial_ge;
  assign trial     = {rem_q, num_sr_q[DIV_STEPS-1]};
  assign trial_sub = trial - {1'b0, span_q};
  assign trial_ge  = trial >= {1'b0, span_q};
  assign div_last  = cnt_q == CNT_W'(DIV_STEPS - 1);

  logic [POS_W-1:0] q_mag;
  assign q_mag = sat_q ? POS_SAT : {1'b0, quot_q};

  logic [ALPHA_W-1:0]       alpha_eff;
  logic signed [POS_W:0]    diff;
  logic signed [ACC_W-1:0]  acc_new, acc_adj;
  logic signed [POS_W-1:0]  sm_cur;

  assign sm_cur    = smooth_q[axis_q];
  assign alpha_eff = (alpha_q > ALPHA_MAX) ? ALPHA_MAX : alpha_q;
  assign diff      = {val_q[POS_W-1], val_q} - {sm_cur[POS_W-1], sm_cur};
  assign acc_new   = $signed({{(ACC_W-POS_W-8){sm_cur[POS_W-1]}}, sm_cur, 8'b0})
                   + ($signed(diff) * $signed({1'b0, alpha_eff}));
  // Bias negative sums so the shift truncates toward zero.
  assign acc_adj   = acc_q + (acc_q[ACC_W-1] ? ACC_W'(255) : ACC_W'(0));

  // ---------------------------------------------------------------------------
  // Control
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_xfer && !kind_i && (int'(axis_i) < AXES)) state_d = S_PREP;
      S_PREP:   state_d = S_CENTER;
      S_CENTER: state_d = in_dz ? S_EMIT : S_DSTART;
      S_DSTART: state_d = S_DIV;
      S_DIV:    if (div_last) state_d = S_VAL;
      S_VAL:    state_d = S_MUL;
      S_MUL:    state_d = S_ROUND;
      S_ROUND:  state_d = S_EMIT;
      S_EMIT:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = state_q != S_IDLE;
    out_free   = !out_valid_q || !out_stall_i;
    out_load   = (state_q == S_EMIT) && out_free;
  end

  assign in_xfer = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Per-axis state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AXES; i++) begin
        center_q[i] <= CENTER_RESET;
        smooth_q[i] <= '0;
      end
      cvalid_q <= '0;
    end else begin
      if (state_q == S_IDLE && in_xfer && kind_i && (int'(axis_i) < AXES)) begin
        center_q[axis_i] <= sample_i;
        cvalid_q[axis_i] <= 1'b1;
      end
      if (state_q == S_CENTER) begin
        center_q[axis_q] <= c_new;
        cvalid_q[axis_q] <= 1'b1;
        if (first_q) smooth_q[axis_q] <= '0;
      end
      if (state_q == S_ROUND && fen_q) begin
        smooth_q[axis_q] <= acc_adj[POS_W+7:8];
      end
    end
  end

  // Working registers of the item in flight
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        axis_q   <= axis_i;
        sample_q <= sample_i;
      end
      S_PREP: begin
        cur_c_q <= c_eff;
        first_q <= !cvalid_q[axis_q];
        neg_q   <= delta[SAMPLE_BITS];
        mag_q   <= delta_abs[SAMPLE_BITS-1:0];
      end
      S_CENTER: begin
        span_q    <= span_new;
        prod_q    <= prod;
        res_dz_q  <= in_dz;
        res_pos_q <= '0;
      end
      S_DSTART: begin
        sat_q    <= sat_new;
        rem_q    <= prod_hi[SAMPLE_BITS-1:0];
        num_sr_q <= {prod_q[7:0], 7'b0};
        quot_q   <= '0;
        cnt_q    <= '0;
      end
      S_DIV: begin
        rem_q    <= trial_ge ? trial_sub[SAMPLE_BITS-1:0]
                                 : trial[SAMPLE_BITS-1:0];
        quot_q   <= {quot_q[DIV_STEPS-2:0], trial_ge};
        num_sr_q <= num_sr_q << 1;
        cnt_q    <= cnt_q + 1'b1;
      end
      S_VAL: begin
        val_q <= neg_q ? -$signed(q_mag) : $signed(q_mag);
      end
      S_MUL: begin
        acc_q <= acc_new;
      end
      S_ROUND: begin
        res_pos_q <= fen_q ? acc_adj[POS_W+7:8] : val_q;
      end
      S_EMIT: ;
      default: ;
    endcase
  end

  // Output register: parts the result from the next transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_axis_q <= axis_q;
      out_pos_q  <= res_pos_q;
      out_dz_q   <= res_dz_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign axis_out_o    = out_axis_q;
  assign position_o    = out_pos_q;
  assign in_deadzone_o = out_dz_q;

  // ---------------------------------------------------------------------------
  // Assertions
  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_EMIT))
    else $error("result appeared without passing the emit state");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_deadzone_o |-> position_o == '0)
    else $error("deadzone result with nonzero position");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> position_o != {1'b1, {(POS_W-1){1'b0}}})
    else $error("position outside the saturated range");

  a_span_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DSTART |-> span_q != '0)
    else $error("divider started with a zero span");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV && !sat_q |-> rem_q < span_q)
    else $error("divider remainder not below the span");

endmodule

// ----- sim/tb_joystick_axis_conditioner_core.sv -----
module tb_joystick_axis_conditioner_core;
  timeunit 1ns;
  timeprecision 1ps;
  import jac_pkg::*;

  localparam int SETTLE_CYCLES = 25;
  localparam int PHASE_ITEMS   = 160;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [PADDR_W-1:0]      paddr;
  logic [PDATA_W-1:0]      pwdata;
  logic [PDATA_W-1:0]      prdata;
  logic                    pready;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic                    kind_i;
  logic [1:0]              axis_i;
  logic [SAMPLE_BITS-1:0]  sample_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [1:0]              axis_out_o;
  logic signed [POS_W-1:0] position_o;
  logic                    in_deadzone_o;

  typedef struct {
    logic [1:0]              axis;
    logic signed [POS_W-1:0] position;
    logic                    in_deadzone;
  } axis_result_t;

  axis_result_t pending_results[$];

  // Our own copy of the register file and of the per-axis state.
  int unsigned dz_cfg    = DZ_RESET;
  int unsigned sens_cfg  = SENS_RESET;
  int unsigned filt_cfg  = 1;
  int unsigned alpha_cfg = ALPHA_RESET;
  int          center_q  [AXES];
  bit          center_ok [AXES];
  int          smooth_q  [AXES];

  int errors;
  int n_samples;
  int n_deadzone;
  int n_recal;
  int n_checked;
  int n_settings;
  int in_quiet;
  int out_quiet;

  joystick_axis_conditioner_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .axis_i        (axis_i),
    .sample_i      (sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .axis_out_o    (axis_out_o),
    .position_o    (position_o),
    .in_deadzone_o (in_deadzone_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Mostly random waits, with occasional runs of back-to-back transfers.
  function automatic int draw_wait(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  function automatic void condition_sample(logic kind, logic [1:0] ax,
                                           logic [SAMPLE_BITS-1:0] s_raw);
    int                s;
    int                delta;
    int                mag;
    int                dz;
    int                span;
    int                val;
    int                a;
    longint unsigned   num;
    longint unsigned   den;
    longint unsigned   q;
    longint            acc;
    axis_result_t      r;
    s = int'(s_raw);
    if (kind) begin
      center_q[ax]  = s;
      center_ok[ax] = 1'b1;
      n_recal++;
      return;
    end
    n_samples++;
    if (!center_ok[ax]) begin
      center_q[ax]  = s;
      center_ok[ax] = 1'b1;
      smooth_q[ax]  = 0;
    end
    delta = s - center_q[ax];
    mag   = (delta < 0) ? -delta : delta;
    dz    = int'(dz_cfg);
    r.axis = ax;
    if (mag <= dz) begin
      center_q[ax]  = (center_q[ax] * 15 + s) / 16;
      r.position    = '0;
      r.in_deadzone = 1'b1;
      n_deadzone++;
      pending_results.push_back(r);
      return;
    end
    if (mag < dz * 3)
      center_q[ax] = (center_q[ax] * 31 + s) / 32;
    span = (delta > 0) ? (int'(SAMPLE_MAX) - center_q[ax]) : center_q[ax];
    if (span < 1)
      span = 1;
    num = longint'(mag) * 64'd32768 * longint'(sens_cfg);
    den = longint'(span) * 64'd256;
    q   = num / den;
    if (q > 64'd32767)
      q = 64'd32767;
    val = (delta < 0) ? -int'(q) : int'(q);
    if (filt_cfg != 0) begin
      a = (alpha_cfg > 256) ? 256 : int'(alpha_cfg);
      acc = longint'(smooth_q[ax]) * (256 - a) + longint'(val) * a;
      smooth_q[ax] = int'(acc / 256);
      val = smooth_q[ax];
    end
    r.position    = val[POS_W-1:0];
    r.in_deadzone = 1'b0;
    pending_results.push_back(r);
  endfunction

  // Every accepted input transfer updates the prediction.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      condition_sample(kind_i, axis_i, sample_i);
  end

  always @(posedge clk_i) begin
    axis_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: axis_out %0d position %0d in_deadzone %0b",
               axis_out_o, position_o, in_deadzone_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (axis_out_o !== want.axis) begin
          $error("axis_out: expected %0d, got %0d", want.axis, axis_out_o);
          errors++;
        end
        if (position_o !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, position_o);
          errors++;
        end
        if (in_deadzone_o !== want.in_deadzone) begin
          $error("in_deadzone: expected %0b, got %0b", want.in_deadzone, in_deadzone_o);
          errors++;
        end
      end
    end
  end

  // Output side: hold off a random number of cycles before each transfer.
  initial begin
    int hold;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      hold = draw_wait(out_quiet);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  task automatic apb_access(input logic wr, input reg_idx_e idx,
                            input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_reg(input reg_idx_e idx, input int unsigned want);
    logic [PDATA_W-1:0] rd;
    apb_access(1'b0, idx, '0, rd);
    if (rd !== PDATA_W'(want)) begin
      $error("register %s: expected %0d, got %0d", idx.name(), want, rd);
      errors++;
    end
  endtask

  task automatic reg_write(input reg_idx_e idx, input int unsigned val);
    logic [PDATA_W-1:0] rd;
    int unsigned        v;
    case (idx)
      REG_DEADZONE: begin
        v = val & 32'hFFF;
        dz_cfg = v;
      end
      REG_SENS: begin
        v = val & 32'h3FF;
        sens_cfg = v;
      end
      REG_FILT_EN: begin
        v = val & 32'h1;
        filt_cfg = v;
      end
      default: begin
        v = val & 32'h1FF;
        alpha_cfg = v;
      end
    endcase
    apb_access(1'b1, idx, PDATA_W'(v), rd);
    check_reg(idx, v);
  endtask

  task automatic send_item(input logic k, input logic [1:0] ax,
                           input logic [SAMPLE_BITS-1:0] s);
    int gap;
    gap = draw_wait(in_quiet);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= k;
    axis_i     <= ax;
    sample_i   <= s;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // A recalibrate gives no result, so after the last one arrives the block may
  // still be busy for a short while.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input int unsigned dz, input int unsigned sens,
                            input int unsigned filt, input int unsigned alpha);
    wait_idle();
    reg_write(REG_DEADZONE, dz);
    reg_write(REG_SENS, sens);
    reg_write(REG_FILT_EN, filt);
    reg_write(REG_ALPHA, alpha);
    n_settings++;
  endtask

  task automatic test_register_defaults();
    check_reg(REG_DEADZONE, DZ_RESET);
    check_reg(REG_SENS, SENS_RESET);
    check_reg(REG_FILT_EN, 1);
    check_reg(REG_ALPHA, ALPHA_RESET);
  endtask

  // Recalibrating an axis before its first sample latches the center without
  // the first-sample path.
  task automatic test_recalibrate_unused_axis();
    send_item(1'b1, 2'd3, 12'd2000);
    send_item(1'b0, 2'd3, 12'd2000);
  endtask

  task automatic test_first_sample();
    send_item(1'b0, 2'd0, 12'd0);
    send_item(1'b0, 2'd1, 12'd4095);
    send_item(1'b0, 2'd2, 12'd2048);
  endtask

  task automatic test_center_tracking();
    send_item(1'b0, 2'd2, 12'd2100);
    send_item(1'b0, 2'd2, 12'd2250);
    send_item(1'b0, 2'd2, 12'd1850);
    send_item(1'b0, 2'd2, 12'd4095);
    send_item(1'b0, 2'd2, 12'd0);
  endtask

  task automatic test_recalibrate_rails();
    send_item(1'b1, 2'd0, 12'd4095);
    send_item(1'b0, 2'd0, 12'd0);
    send_item(1'b1, 2'd1, 12'd0);
    send_item(1'b0, 2'd1, 12'd4095);
    send_item(1'b1, 2'd3, 12'd1000);
    send_item(1'b0, 2'd3, 12'd3000);
  endtask

  task automatic test_gain_and_filter();
    set_config(DZ_RESET, 512, 0, ALPHA_RESET);
    send_item(1'b0, 2'd2, 12'd3000);
    set_config(DZ_RESET, 512, 1, 300);
    send_item(1'b0, 2'd2, 12'd3000);
    set_config(DZ_RESET, 1023, 1, 0);
    send_item(1'b0, 2'd2, 12'd500);
    set_config(0, 0, 1, 256);
    send_item(1'b0, 2'd2, 12'd3500);
  endtask

  // Random phases: the defaults and register extremes first, then random settings. Two
  // samples in five sit around the tracked center so the drift paths get exercised.
  task automatic test_random();
    int          r;
    int          c;
    int          s;
    logic [1:0]  ax;
    logic        k;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: set_config(DZ_RESET, SENS_RESET, 1, ALPHA_RESET);
        1: set_config(0, 512, 1, 256);
        2: set_config(2048, 26, 0, 1);
        3: set_config(4095, 1023, 1, 300);
        4: set_config(5, 0, 1, 0);
        default: set_config($urandom_range(0, 300), $urandom_range(26, 512),
                            $urandom_range(0, 1), $urandom_range(1, 256));
      endcase
      repeat (PHASE_ITEMS) begin
        ax = 2'($urandom_range(0, AXES - 1));
        k  = ($urandom_range(0, 99) < 8);
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7: begin
            r = 3 * int'(dz_cfg) + 8;
            if (r > 4095)
              r = 4095;
            c = center_q[ax];
            s = c + $urandom_range(0, 2 * r) - r;
          end
          8, 9: s = $urandom_range(0, 1) ? 4095 : 0;
          default: s = $urandom_range(0, 4095);
        endcase
        if (s < 0)
          s = 0;
        if (s > 4095)
          s = 4095;
        send_item(k, ax, SAMPLE_BITS'(s));
      end
    end
  endtask

  initial begin
    errors     = 0;
    n_samples  = 0;
    n_deadzone = 0;
    n_recal    = 0;
    n_checked  = 0;
    n_settings = 0;
    in_quiet   = 0;
    out_quiet  = 0;
    for (int i = 0; i < AXES; i++) begin
      center_q[i]  = int'(CENTER_RESET);
      center_ok[i] = 1'b0;
      smooth_q[i]  = 0;
    end
    rst_ni      <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_valid_i  <= 1'b0;
    kind_i      <= 1'b0;
    axis_i      <= '0;
    sample_i    <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_defaults();
    test_recalibrate_unused_axis();
    test_first_sample();
    test_center_tracking();
    test_recalibrate_rails();
    test_gain_and_filter();
    test_random();
    wait_idle();

    $display("Conditioned %0d samples (%0d in the deadzone) and %0d recalibrations",
             n_samples, n_deadzone, n_recal);
    $display("over %0d register settings; %0d results checked.", n_settings, n_checked);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
